>>> rtl/core/vpad_pkg.sv
// Shared types, constants and the arctangent table for the vector pair angle core.
package vpad_pkg;

  localparam int unsigned COORD_WIDTH_DEF     = 16;
  localparam int unsigned ANGLE_FRAC_BITS_DEF = 8;
  localparam int unsigned CORDIC_STAGES_DEF   = 18;

  // angle field width and fixed-point layout of the CORDIC datapath
  localparam int unsigned ANGLE_W   = 17;
  localparam int unsigned Z_FRAC    = 24;
  localparam int unsigned NORM_POS  = 40;
  localparam int unsigned NORM_W    = NORM_POS + 1;
  localparam int unsigned CXW       = 45;
  localparam int unsigned ZW        = 32;
  localparam int unsigned TW        = 34;
  localparam int unsigned MAX_STAGES = 32;

  typedef struct packed {
    logic valid;
    logic degen;
    logic dot_neg;
    logic cross_neg;
  } vpad_side_t;

  // atan(2^-i) in degrees, 24 fraction bits, rounded to nearest
  function automatic logic signed [ZW-1:0] atan_deg(input int unsigned idx);
    logic signed [ZW-1:0] v;
    unique case (idx)
      0:  v = 32'sd754974720;
      1:  v = 32'sd445687602;
      2:  v = 32'sd235489088;
      3:  v = 32'sd119537938;
      4:  v = 32'sd60000934;
      5:  v = 32'sd30029717;
      6:  v = 32'sd15018523;
      7:  v = 32'sd7509720;
      8:  v = 32'sd3754917;
      9:  v = 32'sd1877466;
      10: v = 32'sd938734;
      11: v = 32'sd469367;
      12: v = 32'sd234684;
      13: v = 32'sd117342;
      14: v = 32'sd58671;
      15: v = 32'sd29335;
      16: v = 32'sd14668;
      17: v = 32'sd7334;
      18: v = 32'sd3667;
      19: v = 32'sd1833;
      20: v = 32'sd917;
      21: v = 32'sd458;
      22: v = 32'sd229;
      23: v = 32'sd115;
      24: v = 32'sd57;
      25: v = 32'sd29;
      26: v = 32'sd14;
      27: v = 32'sd7;
      28: v = 32'sd4;
      29: v = 32'sd2;
      30: v = 32'sd1;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> rtl/core/vpad_prod.sv
// Product stage: cross and dot products as sign plus magnitude, three register stages.
module vpad_prod #(
  parameter int unsigned COORD_WIDTH = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_vld,
  input  logic signed [COORD_WIDTH-1:0]    ax,
  input  logic signed [COORD_WIDTH-1:0]    ay,
  input  logic signed [COORD_WIDTH-1:0]    bx,
  input  logic signed [COORD_WIDTH-1:0]    by,
  output vpad_pkg::vpad_side_t             side_o,
  output logic [2*COORD_WIDTH-1:0]         cross_mag_o,
  output logic [2*COORD_WIDTH-1:0]         dot_mag_o
);
  import vpad_pkg::*;

  localparam int unsigned PW = 2 * COORD_WIDTH;

  vpad_side_t           s1_r, s2_r, s3_r;
  logic signed [PW-1:0] axby_r, aybx_r, axbx_r, ayby_r;
  logic signed [PW:0]   cross_r, dot_r;
  logic signed [PW:0]   cross_neg, dot_neg;
  logic [PW-1:0]        cmag_r, dmag_r;
  logic                 degen;

  assign degen = ((ax == '0) && (ay == '0)) || ((bx == '0) && (by == '0));
  assign cross_neg = -cross_r;
  assign dot_neg   = -dot_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_r <= '0;
      s2_r <= '0;
      s3_r <= '0;
    end else begin
      s1_r <= '{valid: in_vld, degen: degen, dot_neg: 1'b0, cross_neg: 1'b0};
      s2_r <= s1_r;
      s3_r <= '{valid: s2_r.valid, degen: s2_r.degen,
                dot_neg: dot_r[PW], cross_neg: cross_r[PW]};
    end
  end

  always_ff @(posedge clk) begin
    axby_r  <= ax * by;
    aybx_r  <= ay * bx;
    axbx_r  <= ax * bx;
    ayby_r  <= ay * by;
    cross_r <= {axby_r[PW-1], axby_r} - {aybx_r[PW-1], aybx_r};
    dot_r   <= {axbx_r[PW-1], axbx_r} + {ayby_r[PW-1], ayby_r};
    // magnitude always fits PW bits: the largest sum is 2^(PW-1)
    cmag_r  <= cross_r[PW] ? cross_neg[PW-1:0] : cross_r[PW-1:0];
    dmag_r  <= dot_r[PW]   ? dot_neg[PW-1:0]   : dot_r[PW-1:0];
  end

  assign side_o      = s3_r;
  assign cross_mag_o = cmag_r;
  assign dot_mag_o   = dmag_r;

endmodule

>>> rtl/core/vpad_nstep.sv
// One step of the joint normaliser: shift both magnitudes left when their top bits are clear.
module vpad_nstep #(
  parameter int unsigned MW    = 32,
  parameter int unsigned SHIFT = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  vpad_pkg::vpad_side_t side_i,
  input  logic [MW-1:0]        cmag_i,
  input  logic [MW-1:0]        dmag_i,
  output vpad_pkg::vpad_side_t side_o,
  output logic [MW-1:0]        cmag_o,
  output logic [MW-1:0]        dmag_o
);
  import vpad_pkg::*;

  vpad_side_t    side_r;
  logic [MW-1:0] cmag_r, dmag_r;
  logic [MW-1:0] both;
  logic          top_clear;

  assign both      = cmag_i | dmag_i;
  assign top_clear = (both[MW-1 -: SHIFT] == '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    cmag_r <= top_clear ? (cmag_i << SHIFT) : cmag_i;
    dmag_r <= top_clear ? (dmag_i << SHIFT) : dmag_i;
  end

  assign side_o = side_r;
  assign cmag_o = cmag_r;
  assign dmag_o = dmag_r;

endmodule

>>> rtl/core/vpad_cell.sv
// One CORDIC vectoring cell: rotate towards the x axis by atan(2^-IDX) and register.
module vpad_cell #(
  parameter int unsigned IDX = 0
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  vpad_pkg::vpad_side_t                  side_i,
  input  logic signed [vpad_pkg::CXW-1:0]       x_i,
  input  logic signed [vpad_pkg::CXW-1:0]       y_i,
  input  logic signed [vpad_pkg::ZW-1:0]        z_i,
  output vpad_pkg::vpad_side_t                  side_o,
  output logic signed [vpad_pkg::CXW-1:0]       x_o,
  output logic signed [vpad_pkg::CXW-1:0]       y_o,
  output logic signed [vpad_pkg::ZW-1:0]        z_o
);
  import vpad_pkg::*;

  localparam logic signed [ZW-1:0] STEP_ANGLE = atan_deg(IDX);

  vpad_side_t            side_r;
  logic signed [CXW-1:0] x_r, y_r, dx, dy;
  logic signed [ZW-1:0]  z_r;

  assign dx = y_i >>> IDX;
  assign dy = x_i >>> IDX;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      side_r <= '0;
    end else begin
      side_r <= side_i;
    end
  end

  always_ff @(posedge clk) begin
    if (y_i[CXW-1]) begin
      x_r <= x_i - dx;
      y_r <= y_i + dy;
      z_r <= z_i - STEP_ANGLE;
    end else begin
      x_r <= x_i + dx;
      y_r <= y_i - dy;
      z_r <= z_i + STEP_ANGLE;
    end
  end

  assign side_o = side_r;
  assign x_o    = x_r;
  assign y_o    = y_r;
  assign z_o    = z_r;

endmodule

>>> rtl/core/vpad_post.sv
// Quadrant fold, wrap into one turn, rounding and the registered result.
module vpad_post #(
  parameter int unsigned ANGLE_FRAC_BITS = 8
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  vpad_pkg::vpad_side_t                side_i,
  input  logic signed [vpad_pkg::ZW-1:0]      z_i,
  output logic                                out_valid,
  output logic [vpad_pkg::ANGLE_W-1:0]        out_angle,
  output logic                                out_degenerate
);
  import vpad_pkg::*;

  localparam int unsigned SH = Z_FRAC - ANGLE_FRAC_BITS;
  localparam int unsigned RW = 9 + ANGLE_FRAC_BITS;
  localparam int unsigned UW = TW - 1;
  localparam logic signed [TW-1:0] HALF_TURN_Z = TW'(180) <<< Z_FRAC;
  localparam logic signed [TW-1:0] FULL_TURN_Z = TW'(360) <<< Z_FRAC;
  localparam logic [UW:0]          ROUND_HALF  = (UW+1)'(1) << (SH - 1);
  localparam logic [RW-1:0]        TURN        = RW'(360) << ANGLE_FRAC_BITS;

  vpad_side_t           p1_r, p2_r, p3_r;
  logic signed [TW-1:0] z_ext, theta_r, theta_up, theta_dn;
  logic [UW-1:0]        wrapped_r;
  logic [UW:0]          rounded;
  logic [RW-1:0]        r_r, r_fold;
  logic                 out_valid_r, out_degen_r;
  logic [RW+ANGLE_W-1:0] angle_ext;
  logic [ANGLE_W-1:0]   out_angle_r;

  assign z_ext    = {{(TW-ZW){z_i[ZW-1]}}, z_i};
  assign theta_up = theta_r + FULL_TURN_Z;
  assign theta_dn = theta_r - FULL_TURN_Z;
  assign rounded  = {1'b0, wrapped_r} + ROUND_HALF;
  assign r_fold   = (r_r >= TURN) ? (r_r - TURN) : r_r;
  assign angle_ext = {{ANGLE_W{1'b0}}, r_fold};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p1_r        <= '0;
      p2_r        <= '0;
      p3_r        <= '0;
      out_valid_r <= 1'b0;
    end else begin
      p1_r        <= side_i;
      p2_r        <= p1_r;
      p3_r        <= p2_r;
      out_valid_r <= p3_r.valid;
    end
  end

  always_ff @(posedge clk) begin
    unique case ({side_i.dot_neg, side_i.cross_neg})
      2'b00:   theta_r <= z_ext;
      2'b10:   theta_r <= HALF_TURN_Z - z_ext;
      2'b11:   theta_r <= HALF_TURN_Z + z_ext;
      default: theta_r <= FULL_TURN_Z - z_ext;
    endcase
    priority if (theta_r[TW-1]) begin
      wrapped_r <= theta_up[UW-1:0];
    end else if (theta_r >= FULL_TURN_Z) begin
      wrapped_r <= theta_dn[UW-1:0];
    end else begin
      wrapped_r <= theta_r[UW-1:0];
    end
    r_r <= rounded[SH +: RW];
    out_degen_r <= p3_r.degen;
    // zero-length input forces the angle to zero
    out_angle_r <= p3_r.degen ? '0 : angle_ext[ANGLE_W-1:0];
  end

  assign out_valid      = out_valid_r;
  assign out_angle      = out_angle_r;
  assign out_degenerate = out_degen_r;

endmodule

>>> rtl/core/vector_pair_angle_degrees_core.sv
// Top level of the vector pair angle core: products, normaliser, CORDIC cell row, rounding.
// Takes one request per clock and returns the counter-clockwise angle from the first vector
// to the second in [0,360) degrees, in units of 2^-ANGLE_FRAC_BITS degree. busy is held low:
// a request may be issued every cycle. Each result passes through three product stages, one
// normaliser stage per shift step, one CORDIC cell per stage and four output stages.
// out_valid is high for exactly one cycle per result and cannot be held off, so the
// receiver must take every result in the cycle it appears. A request with a zero-length
// vector returns angle 0 with out_degenerate set.
module vector_pair_angle_degrees_core #(
  parameter int unsigned COORD_WIDTH     = vpad_pkg::COORD_WIDTH_DEF,
  parameter int unsigned ANGLE_FRAC_BITS = vpad_pkg::ANGLE_FRAC_BITS_DEF,
  parameter int unsigned CORDIC_STAGES   = vpad_pkg::CORDIC_STAGES_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COORD_WIDTH-1:0] in_first_x,
  input  logic signed [COORD_WIDTH-1:0] in_first_y,
  input  logic signed [COORD_WIDTH-1:0] in_second_x,
  input  logic signed [COORD_WIDTH-1:0] in_second_y,
  output logic                          out_valid,
  output logic [vpad_pkg::ANGLE_W-1:0]  out_angle,
  output logic                          out_degenerate
);
  import vpad_pkg::*;

  localparam int unsigned MW   = 2 * COORD_WIDTH;
  localparam int unsigned NS   = $clog2(MW);
  localparam int unsigned NSTG = (CORDIC_STAGES < MAX_STAGES) ? CORDIC_STAGES : MAX_STAGES;

  vpad_side_t            ns_w [0:NS];
  logic [MW-1:0]         nc_w [0:NS];
  logic [MW-1:0]         nd_w [0:NS];
  logic [NORM_W-1:0]     x_al, y_al;
  vpad_side_t            cs_w [0:NSTG];
  logic signed [CXW-1:0] cx_w [0:NSTG];
  logic signed [CXW-1:0] cy_w [0:NSTG];
  logic signed [ZW-1:0]  cz_w [0:NSTG];

  assign busy = 1'b0;

  vpad_prod #(
    .COORD_WIDTH(COORD_WIDTH)
  ) u_prod (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_vld     (start),
    .ax         (in_first_x),
    .ay         (in_first_y),
    .bx         (in_second_x),
    .by         (in_second_y),
    .side_o     (ns_w[0]),
    .cross_mag_o(nc_w[0]),
    .dot_mag_o  (nd_w[0])
  );

  for (genvar k = 0; k < NS; k++) begin : g_norm
    vpad_nstep #(
      .MW   (MW),
      .SHIFT(1 << (NS - 1 - k))
    ) u_nstep (
      .clk   (clk),
      .rst_n (rst_n),
      .side_i(ns_w[k]),
      .cmag_i(nc_w[k]),
      .dmag_i(nd_w[k]),
      .side_o(ns_w[k+1]),
      .cmag_o(nc_w[k+1]),
      .dmag_o(nd_w[k+1])
    );
  end

  // place the leading one at NORM_POS: drop low bits or pad with zeros
  if (MW >= NORM_W) begin : g_align_dn
    assign x_al = nd_w[NS][MW-1 -: NORM_W];
    assign y_al = nc_w[NS][MW-1 -: NORM_W];
  end else begin : g_align_up
    assign x_al = {nd_w[NS], {(NORM_W-MW){1'b0}}};
    assign y_al = {nc_w[NS], {(NORM_W-MW){1'b0}}};
  end

  assign cs_w[0] = ns_w[NS];
  assign cx_w[0] = {{(CXW-NORM_W){1'b0}}, x_al};
  assign cy_w[0] = {{(CXW-NORM_W){1'b0}}, y_al};
  assign cz_w[0] = '0;

  for (genvar i = 0; i < NSTG; i++) begin : g_cell
    vpad_cell #(
      .IDX(i)
    ) u_cell (
      .clk   (clk),
      .rst_n (rst_n),
      .side_i(cs_w[i]),
      .x_i   (cx_w[i]),
      .y_i   (cy_w[i]),
      .z_i   (cz_w[i]),
      .side_o(cs_w[i+1]),
      .x_o   (cx_w[i+1]),
      .y_o   (cy_w[i+1]),
      .z_o   (cz_w[i+1])
    );
  end

  vpad_post #(
    .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
  ) u_post (
    .clk           (clk),
    .rst_n         (rst_n),
    .side_i        (cs_w[NSTG]),
    .z_i           (cz_w[NSTG]),
    .out_valid     (out_valid),
    .out_angle     (out_angle),
    .out_degenerate(out_degenerate)
  );

endmodule

>>> test/testbench.sv
// Testbench for the vector pair angle core: directed and random vector pairs against a predictor.
`timescale 1ns / 1ps

module testbench;

  localparam int COORD_W   = vpad_pkg::COORD_WIDTH_DEF;
  localparam int FRAC_BITS = vpad_pkg::ANGLE_FRAC_BITS_DEF;
  localparam int STAGES    = vpad_pkg::CORDIC_STAGES_DEF;
  localparam int Z_BITS    = vpad_pkg::Z_FRAC;
  localparam int NORM_AT   = vpad_pkg::NORM_POS;
  localparam int LATENCY   = 8 + $clog2(2 * COORD_W) + STAGES;
  localparam int RANDOM_PAIRS = 900;
  localparam int PRINT_CAP    = 60;

  // atan(2^-i) in degrees, 24 fraction bits
  localparam longint ATAN_DEG_Q24 [32] = '{
    754974720, 445687602, 235489088, 119537938,
    60000934, 30029717, 15018523, 7509720,
    3754917, 1877466, 938734, 469367,
    234684, 117342, 58671, 29335,
    14668, 7334, 3667, 1833,
    917, 458, 229, 115,
    57, 29, 14, 7,
    4, 2, 1, 0
  };

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct {
    coord_t                       ax;
    coord_t                       ay;
    coord_t                       bx;
    coord_t                       by;
    logic [vpad_pkg::ANGLE_W-1:0] angle;
    logic                         degen;
  } angle_req_t;

  logic   clk = 1'b0;
  logic   rst_n = 1'b0;
  logic   start = 1'b0;
  coord_t in_first_x = '0;
  coord_t in_first_y = '0;
  coord_t in_second_x = '0;
  coord_t in_second_y = '0;
  logic                         busy;
  logic                         out_valid;
  logic [vpad_pkg::ANGLE_W-1:0] out_angle;
  logic                         out_degenerate;

  angle_req_t  pending_angles[$];
  int unsigned mismatch_count = 0;
  int unsigned results_checked = 0;
  int unsigned requests_sent = 0;
  int unsigned zero_len_count = 0;
  bit          steady_run = 1'b0;

  vector_pair_angle_degrees_core DUT (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_first_x    (in_first_x),
    .in_first_y    (in_first_y),
    .in_second_x   (in_second_x),
    .in_second_y   (in_second_y),
    .out_valid     (out_valid),
    .out_angle     (out_angle),
    .out_degenerate(out_degenerate)
  );

  always #6 clk = ~clk;

  initial begin
    #(5_000_000);
    $display("testbench NOT OK");
    $finish;
  end

  task automatic report_mismatch(input string what);
    if (mismatch_count < PRINT_CAP)
      $display("[%0t] MISMATCH: %s", $realtime, what);
    mismatch_count++;
  endtask

  // Counter-clockwise angle from a to b, atan2 by first-quadrant CORDIC, 1/256 degree units.
  function automatic angle_req_t predict_angle(input coord_t ax, ay, bx, by);
    angle_req_t res;
    longint     cross_v, dot_v, mc, md, top, x, y, z, dx, dy, theta, full, r, turn;
    int         p;
    res.ax = ax;
    res.ay = ay;
    res.bx = bx;
    res.by = by;
    res.angle = '0;
    res.degen = 1'b0;
    if ((ax == 0 && ay == 0) || (bx == 0 && by == 0)) begin
      res.degen = 1'b1;
      return res;
    end
    cross_v = longint'(ax) * longint'(by) - longint'(ay) * longint'(bx);
    dot_v   = longint'(ax) * longint'(bx) + longint'(ay) * longint'(by);
    mc = (cross_v < 0) ? -cross_v : cross_v;
    md = (dot_v < 0) ? -dot_v : dot_v;
    // normalise both so the larger has its top bit at NORM_AT
    top = mc | md;
    p = 0;
    while (p < 63 && (top >> (p + 1)) != 0)
      p++;
    if (p > NORM_AT) begin
      mc = mc >> (p - NORM_AT);
      md = md >> (p - NORM_AT);
    end else begin
      mc = mc << (NORM_AT - p);
      md = md << (NORM_AT - p);
    end
    x = md;
    y = mc;
    z = 0;
    for (int i = 0; i < STAGES && i < 32; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (y >= 0) begin
        x += dx;
        y -= dy;
        z += ATAN_DEG_Q24[i];
      end else begin
        x -= dx;
        y += dy;
        z -= ATAN_DEG_Q24[i];
      end
    end
    full = longint'(360) << Z_BITS;
    if (dot_v >= 0 && cross_v >= 0)
      theta = z;
    else if (dot_v < 0 && cross_v >= 0)
      theta = (longint'(180) << Z_BITS) - z;
    else if (dot_v < 0)
      theta = (longint'(180) << Z_BITS) + z;
    else
      theta = full - z;
    if (theta < 0)
      theta += full;
    else if (theta >= full)
      theta -= full;
    r = (theta + (longint'(1) << (Z_BITS - FRAC_BITS - 1))) >>> (Z_BITS - FRAC_BITS);
    turn = longint'(360) << FRAC_BITS;
    if (r >= turn)
      r -= turn;
    res.angle = r[vpad_pkg::ANGLE_W-1:0];
    return res;
  endfunction

  function automatic int unsigned pick_gap();
    int unsigned roll;
    if (steady_run)
      return 0;
    roll = $urandom_range(0, 99);
    if (roll < 55)
      return 0;
    if (roll < 92)
      return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Hold the request until it is taken, log the expected result, then idle for a random gap, which may be none.
  task automatic send_pair(input coord_t ax, ay, bx, by);
    angle_req_t  req;
    int unsigned gap;
    in_first_x  <= ax;
    in_first_y  <= ay;
    in_second_x <= bx;
    in_second_y <= by;
    start       <= 1'b1;
    do @(posedge clk); while (busy !== 1'b0);
    req = predict_angle(ax, ay, bx, by);
    pending_angles.push_back(req);
    requests_sent++;
    if (req.degen)
      zero_len_count++;
    gap = pick_gap();
    if (gap != 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  always @(posedge clk) begin : check_results
    angle_req_t exp_r;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_angles.size() == 0) begin
        report_mismatch($sformatf("unexpected result angle %0d degenerate %0b",
                                  out_angle, out_degenerate));
      end else begin
        exp_r = pending_angles.pop_front();
        results_checked++;
        if (out_angle !== exp_r.angle)
          report_mismatch($sformatf("a=(%0d,%0d) b=(%0d,%0d): angle %0d, expected %0d",
                                    exp_r.ax, exp_r.ay, exp_r.bx, exp_r.by,
                                    out_angle, exp_r.angle));
        if (out_degenerate !== exp_r.degen)
          report_mismatch($sformatf("a=(%0d,%0d) b=(%0d,%0d): degenerate %0b, expected %0b",
                                    exp_r.ax, exp_r.ay, exp_r.bx, exp_r.by,
                                    out_degenerate, exp_r.degen));
      end
    end
  end

  task automatic test_zero_length();
    send_pair(16'sd0, 16'sd0, 16'sd5, 16'sd7);
    send_pair(16'sd3, -16'sd4, 16'sd0, 16'sd0);
    send_pair(16'sd0, 16'sd0, 16'sd0, 16'sd0);
    send_pair(16'sd0, 16'sd0, -16'sd32768, -16'sd32768);
  endtask

  // Axes, all four quadrants, same and opposite direction, residue just either side of zero.
  task automatic test_directions();
    send_pair(16'sd1, 16'sd0, 16'sd1, 16'sd0);
    send_pair(16'sd1, 16'sd0, -16'sd1, 16'sd0);
    send_pair(16'sd1, 16'sd0, 16'sd0, 16'sd1);
    send_pair(16'sd1, 16'sd0, 16'sd0, -16'sd1);
    send_pair(16'sd32767, 16'sd32767, -16'sd32768, -16'sd32768);
    send_pair(-16'sd32768, -16'sd32768, -16'sd32768, -16'sd32768);
    send_pair(16'sd1, 16'sd0, 16'sd32767, -16'sd1);
    send_pair(16'sd1, 16'sd0, 16'sd32767, 16'sd1);
    send_pair(16'sd3, 16'sd4, -16'sd4, 16'sd3);
    send_pair(-16'sd5, 16'sd2, 16'sd7, -16'sd9);
    send_pair(16'sd2, -16'sd3, -16'sd7, -16'sd1);
    send_pair(-16'sd32768, 16'sd0, 16'sd0, -16'sd32768);
    send_pair(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
  endtask

  task automatic test_field_extremes();
    send_pair(-16'sd32768, -16'sd32768, 16'sd32767, 16'sd32767);
    send_pair(16'sd32767, -16'sd32768, -16'sd32768, 16'sd32767);
    send_pair(-16'sd1, -16'sd1, 16'sd1, 16'sd1);
    send_pair(16'sd32767, 16'sd0, -16'sd32768, 16'sd1);
    send_pair(-16'sd32768, 16'sd32767, -16'sd1, -16'sd32768);
    send_pair(16'sd1, -16'sd1, -16'sd1, 16'sd1);
  endtask

  function automatic coord_t extreme_coord();
    case ($urandom_range(0, 5))
      0: return -16'sd32768;
      1: return -16'sd32767;
      2: return -16'sd1;
      3: return 16'sd0;
      4: return 16'sd1;
      default: return 16'sd32767;
    endcase
  endfunction

  task automatic test_random_pairs();
    coord_t ax, ay, bx, by;
    int     k;
    for (int n = 0; n < RANDOM_PAIRS; n++) begin
      // every fourth stretch of 60 requests runs back to back
      steady_run = ((n / 60) % 4 == 1);
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          ax = coord_t'($urandom());
          ay = coord_t'($urandom());
          bx = coord_t'($urandom());
          by = coord_t'($urandom());
        end
        5: begin
          ax = coord_t'(int'($urandom_range(0, 16)) - 8);
          ay = coord_t'(int'($urandom_range(0, 16)) - 8);
          bx = coord_t'(int'($urandom_range(0, 16)) - 8);
          by = coord_t'(int'($urandom_range(0, 16)) - 8);
        end
        6, 7: begin
          // near collinear: scaled copy plus a nudge of at most one
          ax = coord_t'(int'($urandom_range(0, 4000)) - 2000);
          ay = coord_t'(int'($urandom_range(0, 4000)) - 2000);
          k = int'($urandom_range(1, 15));
          if ($urandom_range(0, 1))
            k = -k;
          bx = coord_t'(int'(ax) * k + int'($urandom_range(0, 2)) - 1);
          by = coord_t'(int'(ay) * k + int'($urandom_range(0, 2)) - 1);
        end
        8: begin
          ax = extreme_coord();
          ay = extreme_coord();
          bx = extreme_coord();
          by = extreme_coord();
        end
        default: begin
          ax = coord_t'($urandom());
          ay = coord_t'($urandom());
          bx = coord_t'($urandom());
          by = coord_t'($urandom());
          if ($urandom_range(0, 1)) begin
            ax = '0;
            ay = '0;
          end else begin
            bx = '0;
            by = '0;
          end
        end
      endcase
      send_pair(ax, ay, bx, by);
    end
    steady_run = 1'b0;
  endtask

  task automatic drain_results();
    angle_req_t  left;
    int unsigned guard;
    start <= 1'b0;
    guard = 0;
    while (pending_angles.size() != 0 && guard < 8 * LATENCY) begin
      @(posedge clk);
      guard++;
    end
    repeat (LATENCY + 8) @(posedge clk);
    while (pending_angles.size() != 0) begin
      left = pending_angles.pop_front();
      report_mismatch($sformatf("no result for a=(%0d,%0d) b=(%0d,%0d)",
                                left.ax, left.ay, left.bx, left.by));
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_zero_length();
    test_directions();
    test_field_extremes();
    test_random_pairs();
    drain_results();
    $display("Checked %0d results from %0d requests, %0d with a zero-length vector.",
             results_checked, requests_sent, zero_len_count);
    $display("Covered axes, all quadrants, collinear pairs, field extremes and random gaps.");
    if (mismatch_count == 0)
      $display("testbench OK");
    else
      $display("testbench NOT OK");
    $finish;
  end

endmodule

>>> files.f
rtl/core/vpad_pkg.sv
rtl/core/vpad_prod.sv
rtl/core/vpad_nstep.sv
rtl/core/vpad_cell.sv
rtl/core/vpad_post.sv
rtl/core/vector_pair_angle_degrees_core.sv
test/testbench.sv
